// ===== src/kuw_pkg.sv =====
// ----------------------------------------------------------------------------
// Kuwahara filter package
// Shared types and constants of the four-quadrant Kuwahara filter.
// ----------------------------------------------------------------------------
package kuw_pkg;

  // Number of quadrants, visited in the order TL, TR, BL, BR.
  localparam int Quads = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BRD,
    ST_SCAN,
    ST_FLUSH,
    ST_SCORE,
    ST_CHAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } kuw_state_e;

  // Control broadcast from the sequencer to every quadrant cell.
  typedef struct packed {
    logic       clear;
    logic       acc;
    logic       score;
    logic [1:0] ch;
  } kuw_cell_ctrl_t;

endpackage

// ===== src/kuw_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one input pixel or filler beat.
// ----------------------------------------------------------------------------
interface kuw_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic       filler;

  modport source (output valid, blue_in, green_in, red_in, filler, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, filler, output ready);
endinterface

// ===== src/kuw_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying one filtered or copied pixel.
// ----------------------------------------------------------------------------
interface kuw_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_end;

  modport source (output valid, blue_out, green_out, red_out, frame_end, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, frame_end, output ready);
endinterface

// ===== src/kuw_cell.sv =====
// ----------------------------------------------------------------------------
// Quadrant cell
// Accumulates the channel sums and sums of squares of one quadrant, forms
// its score, and passes the best quadrant so far on to its neighbor.
// ----------------------------------------------------------------------------
module kuw_cell #(
  parameter int MAX_RADIUS = 7
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  kuw_pkg::kuw_cell_ctrl_t                ctrl_i,
  input  logic                                   tag_i,
  input  logic [23:0]                            pix_i,
  input  logic [$clog2((MAX_RADIUS+1)**2+1)-1:0] n_i,
  input  logic                                   have_i,
  input  logic [$clog2(64'(3)*((MAX_RADIUS+1)**2)*((MAX_RADIUS+1)**2)*65025+1)-1:0]
                                                 score_i,
  input  logic [2:0][$clog2((MAX_RADIUS+1)**2*255+1)-1:0] sum_i,
  output logic                                   have_o,
  output logic [$clog2(64'(3)*((MAX_RADIUS+1)**2)*((MAX_RADIUS+1)**2)*65025+1)-1:0]
                                                 score_o,
  output logic [2:0][$clog2((MAX_RADIUS+1)**2*255+1)-1:0] sum_o
);

  localparam int    NMax  = (MAX_RADIUS + 1) ** 2;
  localparam int    NW    = $clog2(NMax + 1);
  localparam int    SW    = $clog2(NMax * 255 + 1);
  localparam int    QW    = $clog2(NMax * 65025 + 1);
  localparam longint ScMax = 64'(3) * NMax * NMax * 65025;
  localparam int    SCW   = $clog2(ScMax + 1);

  logic [2:0][SW-1:0] s_q;
  logic [2:0][QW-1:0] q_q;
  logic [SCW-1:0]     sc_q;
  logic [SW-1:0]      s_sel;
  logic [QW-1:0]      q_sel;
  logic [NW+QW-1:0]   nq;
  logic [2*SW-1:0]    ss;
  logic               mine;
  logic               have_q;
  logic [SCW-1:0]     best_sc_q;
  logic [2:0][SW-1:0] best_s_q;

  // Channel select for the scoring pass.
  always_comb begin
    case (ctrl_i.ch)
      2'd0:    begin s_sel = s_q[0]; q_sel = q_q[0]; end
      2'd1:    begin s_sel = s_q[1]; q_sel = q_q[1]; end
      2'd2:    begin s_sel = s_q[2]; q_sel = q_q[2]; end
      default: begin s_sel = '0;     q_sel = '0;     end
    endcase
  end

  assign nq = n_i * q_sel;
  assign ss = s_sel * s_sel;

  // Sums, sums of squares and score of this quadrant.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      s_q  <= '0;
      q_q  <= '0;
      sc_q <= '0;
    end else begin
      if (ctrl_i.acc && tag_i) begin
        for (int c = 0; c < 3; c++) begin
          s_q[c] <= s_q[c] + SW'(pix_i[8*c +: 8]);
          q_q[c] <= q_q[c] + QW'(16'(pix_i[8*c +: 8]) * 16'(pix_i[8*c +: 8]));
        end
      end
      if (ctrl_i.score) begin
        sc_q <= sc_q + SCW'(nq) - SCW'(ss);
      end
    end
  end

  // An earlier quadrant keeps its place on a tie.
  assign mine = !have_i || (sc_q < score_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    best_sc_q <= mine ? sc_q : score_i;
    best_s_q  <= mine ? s_q  : sum_i;
  end

  assign have_o  = have_q;
  assign score_o = best_sc_q;
  assign sum_o   = best_s_q;

endmodule

// ===== src/kuw_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kuw_div #(
  parameter int MAX_RADIUS = 7
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [$clog2((MAX_RADIUS+1)**2*255+1)-1:0] dividend_i,
  input  logic [$clog2((MAX_RADIUS+1)**2+1)-1:0] divisor_i,
  output logic                                   done_o,
  output logic [$clog2((MAX_RADIUS+1)**2*255+1)-1:0] quo_o,
  output logic [$clog2((MAX_RADIUS+1)**2+1)-1:0] rem_o
);

  localparam int NMax = (MAX_RADIUS + 1) ** 2;
  localparam int NW   = $clog2(NMax + 1);
  localparam int SW   = $clog2(NMax * 255 + 1);
  localparam int CNW  = $clog2(SW + 1);

  logic           busy_q;
  logic           done_q;
  logic [CNW-1:0] cnt_q;
  logic [SW-1:0]  quo_q;
  logic [NW-1:0]  rem_q;
  logic [NW:0]    trial;
  logic           fits;

  assign trial = {rem_q, quo_q[SW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(SW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // One quotient bit a cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? NW'(trial - {1'b0, divisor_i}) : NW'(trial);
      quo_q <= {quo_q[SW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/kuwahara_filter.sv =====
// The time a filtered pixel takes is set by the window scan through the one read
// port of the line store and by the serial divider. Items are handled one at a
// time, so the next input item is taken only once the last is through; a result
// that finds the output register full waits and holds off the input.
// Reset clears all counters and loads radius 5, width 300, height 225.
// ----------------------------------------------------------------------------
// Kuwahara filter, four-quadrant form
// Raster-order 3-channel filter with a line store, a chain of quadrant cells
// that picks the smoothest quadrant, and a serial divider for the mean.
// ----------------------------------------------------------------------------
module kuwahara_filter #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kuw_pix_in_if.sink           pix_i,
  kuw_pix_out_if.source        res_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [11:0]          cfg_data_i
);

  localparam int     NMax  = (MAX_RADIUS + 1) ** 2;
  localparam int     NW    = $clog2(NMax + 1);
  localparam int     SW    = $clog2(NMax * 255 + 1);
  localparam longint ScMax = 64'(3) * NMax * NMax * 65025;
  localparam int     SCW   = $clog2(ScMax + 1);
  localparam int     RW    = $clog2(MAX_RADIUS + 1);
  localparam int     Rows  = 2 * MAX_RADIUS + 1;
  localparam int     SLW   = $clog2(Rows);
  localparam int     WW    = $clog2(MAX_WIDTH + 1);
  localparam int     Depth = Rows * MAX_WIDTH;
  localparam int     AW    = $clog2(Depth);
  localparam int     DW    = $clog2(2 * MAX_RADIUS + 1);
  localparam int     PW    = $clog2(MAX_WIDTH * 4095 + 1);
  localparam int     NQ    = kuw_pkg::Quads;
  localparam int     CTW   = $clog2(NQ);

  // Configuration registers and their effective values.
  logic [2:0]  radius_q;
  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [31:0] w_tmp;
  logic [31:0] r_tmp;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] r_eff;
  logic [11:0]   h_eff;
  logic [PW-1:0] total;
  logic [PW-1:0] lag;
  logic [NW-1:0] n_cnt;

  always_comb begin
    w_tmp = (width_q == 11'd0) ? 32'd1 :
            ((32'(width_q) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_q));
    r_tmp = (32'(radius_q) > MAX_RADIUS) ? 32'(MAX_RADIUS) : 32'(radius_q);
    w_eff = WW'(w_tmp);
    r_eff = RW'(r_tmp);
    h_eff = (height_q == 12'd0) ? 12'd1 : height_q;
    total = PW'(PW'(w_eff) * PW'(h_eff));
    lag   = PW'(PW'(r_eff) * PW'(w_eff) + PW'(r_eff));
    n_cnt = NW'((r_eff + 1) * (r_eff + 1));
  end

  // Sequencer state.
  kuw_pkg::kuw_state_e state_q, state_d;
  logic [WW-1:0]  in_col_q, in_col_d;
  logic [11:0]    in_row_q, in_row_d;
  logic [SLW-1:0] in_slot_q, in_slot_d;
  logic [PW-1:0]  rcv_q, rcv_d;
  logic [PW-1:0]  out_pos_q, out_pos_d;
  logic [WW-1:0]  out_col_q, out_col_d;
  logic [11:0]    out_row_q, out_row_d;
  logic [SLW-1:0] out_slot_q, out_slot_d;
  logic [DW-1:0]  dy_q, dy_d, dx_q, dx_d;
  logic [SLW-1:0] wslot_q, wslot_d;
  logic [CTW:0]   cnt_q, cnt_d;
  logic [23:0]    res_q, res_d;
  logic           pix_vld_q, pix_vld_d;
  logic [NQ-1:0]  tag_q, tag_d;
  logic           out_vld_q, out_vld_d;
  logic [23:0]    out_pix_q, out_pix_d;
  logic           out_end_q, out_end_d;

  // Line store.
  logic [23:0]   mem [Depth];
  logic [23:0]   rd_q;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Cell chain and divider.
  kuw_pkg::kuw_cell_ctrl_t ctrl;
  logic                    have_c  [NQ+1];
  logic [SCW-1:0]          score_c [NQ+1];
  logic [2:0][SW-1:0]      sum_c   [NQ+1];
  logic                    div_start;
  logic [SW-1:0]           div_num;
  logic                    div_done;
  logic [SW-1:0]           div_quo;
  logic [NW-1:0]           div_rem;
  logic [NW:0]             rem2;
  logic                    rnd_up;
  logic [SW:0]             q_rnd;
  logic [7:0]              mean;

  // Helper values of the current output position.
  logic           due;
  logic           border;
  logic [SLW-1:0] start_slot;
  logic [WW-1:0]  xb;
  logic [DW-1:0]  r_dw;
  logic [DW-1:0]  two_r;
  logic           last_out;

  assign r_dw  = DW'(r_eff);
  assign two_r = DW'(r_dw << 1);
  assign xb    = out_col_q - WW'(r_eff);
  assign due   = (in_row_q >= h_eff) ||
                 ({1'b0, rcv_q} > ({1'b0, out_pos_q} + (PW+1)'(lag)));
  assign border = (out_row_q < 12'(r_eff)) || (out_col_q < WW'(r_eff)) ||
                  ((13'(out_row_q) + 13'(r_eff)) >= 13'(h_eff)) ||
                  (((WW+1)'(out_col_q) + (WW+1)'(r_eff)) >= (WW+1)'(w_eff));
  assign start_slot = (out_slot_q >= SLW'(r_eff)) ? (out_slot_q - SLW'(r_eff)) :
                      SLW'(out_slot_q + SLW'(Rows) - SLW'(r_eff));
  assign last_out = ((out_pos_q + PW'(1)) == total);
  assign wr_addr  = AW'(AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q));

  // Rounding of the mean, halves to even.
  assign rem2   = {div_rem, 1'b0};
  assign rnd_up = (rem2 > {1'b0, n_cnt}) || ((rem2 == {1'b0, n_cnt}) && div_quo[0]);
  assign q_rnd  = {1'b0, div_quo} + (SW+1)'(rnd_up);
  assign mean   = (q_rnd > (SW+1)'(255)) ? 8'hFF : q_rnd[7:0];

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    div_num = sum_c[NQ][0];
      2'd1:    div_num = sum_c[NQ][1];
      2'd2:    div_num = sum_c[NQ][2];
      default: div_num = '0;
    endcase
  end

  // Next state and outputs of the sequencer.
  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    rcv_d      = rcv_q;
    out_pos_d  = out_pos_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    dy_d       = dy_q;
    dx_d       = dx_q;
    wslot_d    = wslot_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    pix_vld_d  = 1'b0;
    tag_d      = tag_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    out_pix_d  = out_pix_q;
    out_end_d  = out_end_q;
    mem_we     = 1'b0;
    rd_addr    = AW'(AW'(wslot_q) * AW'(MAX_WIDTH) + AW'(xb + WW'(dx_q)));
    ctrl       = '0;
    ctrl.acc   = pix_vld_q;
    div_start  = 1'b0;
    pix_i.ready = 1'b0;

    case (state_q)
      kuw_pkg::ST_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) begin
          if (!pix_i.filler && (in_row_q < h_eff)) begin
            mem_we = 1'b1;
            rcv_d  = rcv_q + PW'(1);
            if (((WW+1)'(in_col_q) + (WW+1)'(1)) >= (WW+1)'(w_eff)) begin
              in_col_d  = '0;
              in_row_d  = in_row_q + 12'd1;
              in_slot_d = (in_slot_q == SLW'(Rows - 1)) ? '0 : in_slot_q + SLW'(1);
            end else begin
              in_col_d = in_col_q + WW'(1);
            end
          end
          state_d = kuw_pkg::ST_CHECK;
        end
      end
      kuw_pkg::ST_CHECK: begin
        if ((out_pos_q >= total) || !due) begin
          state_d = kuw_pkg::ST_IDLE;
        end else if (border) begin
          rd_addr = AW'(AW'(out_slot_q) * AW'(MAX_WIDTH) + AW'(out_col_q));
          state_d = kuw_pkg::ST_BRD;
        end else begin
          ctrl.clear = 1'b1;
          dy_d       = '0;
          dx_d       = '0;
          wslot_d    = start_slot;
          state_d    = kuw_pkg::ST_SCAN;
        end
      end
      kuw_pkg::ST_BRD: begin
        res_d   = rd_q;
        state_d = kuw_pkg::ST_EMIT;
      end
      kuw_pkg::ST_SCAN: begin
        // One window pixel a cycle, tagged with the quadrants it belongs to.
        pix_vld_d = 1'b1;
        tag_d[0]  = (dy_q <= r_dw) && (dx_q <= r_dw);
        tag_d[1]  = (dy_q <= r_dw) && (dx_q >= r_dw);
        tag_d[2]  = (dy_q >= r_dw) && (dx_q <= r_dw);
        tag_d[3]  = (dy_q >= r_dw) && (dx_q >= r_dw);
        if (dx_q == two_r) begin
          dx_d    = '0;
          dy_d    = dy_q + DW'(1);
          wslot_d = (wslot_q == SLW'(Rows - 1)) ? '0 : wslot_q + SLW'(1);
          if (dy_q == two_r) begin
            state_d = kuw_pkg::ST_FLUSH;
          end
        end else begin
          dx_d = dx_q + DW'(1);
        end
      end
      kuw_pkg::ST_FLUSH: begin
        cnt_d   = '0;
        state_d = kuw_pkg::ST_SCORE;
      end
      kuw_pkg::ST_SCORE: begin
        ctrl.score = 1'b1;
        ctrl.ch    = cnt_q[1:0];
        if (cnt_q == (CTW+1)'(2)) begin
          cnt_d   = '0;
          state_d = kuw_pkg::ST_CHAIN;
        end else begin
          cnt_d = cnt_q + (CTW+1)'(1);
        end
      end
      kuw_pkg::ST_CHAIN: begin
        // The best quadrant ripples one cell a cycle.
        if (cnt_q == (CTW+1)'(NQ - 1)) begin
          cnt_d   = '0;
          state_d = kuw_pkg::ST_DIV_GO;
        end else begin
          cnt_d = cnt_q + (CTW+1)'(1);
        end
      end
      kuw_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = kuw_pkg::ST_DIV_WAIT;
      end
      kuw_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          case (cnt_q[1:0])
            2'd0:    res_d[7:0]   = mean;
            2'd1:    res_d[15:8]  = mean;
            default: res_d[23:16] = mean;
          endcase
          if (cnt_q == (CTW+1)'(2)) begin
            cnt_d   = '0;
            state_d = kuw_pkg::ST_EMIT;
          end else begin
            cnt_d   = cnt_q + (CTW+1)'(1);
            state_d = kuw_pkg::ST_DIV_GO;
          end
        end
      end
      kuw_pkg::ST_EMIT: begin
        if (!out_vld_q || res_o.ready) begin
          out_vld_d = 1'b1;
          out_pix_d = res_q;
          out_end_d = last_out;
          if (last_out) begin
            in_col_d   = '0;
            in_row_d   = '0;
            in_slot_d  = '0;
            rcv_d      = '0;
            out_pos_d  = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            out_slot_d = '0;
          end else begin
            out_pos_d = out_pos_q + PW'(1);
            if (((WW+1)'(out_col_q) + (WW+1)'(1)) >= (WW+1)'(w_eff)) begin
              out_col_d  = '0;
              out_row_d  = out_row_q + 12'd1;
              out_slot_d = (out_slot_q == SLW'(Rows - 1)) ? '0 : out_slot_q + SLW'(1);
            end else begin
              out_col_d = out_col_q + WW'(1);
            end
          end
          state_d = kuw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kuw_pkg::ST_IDLE;
      end
    endcase

    // A register write abandons the current frame.
    if (cfg_we_i && ((cfg_idx_i == kuw_pkg::CFG_RADIUS) ||
                     (cfg_idx_i == kuw_pkg::CFG_WIDTH) ||
                     (cfg_idx_i == kuw_pkg::CFG_HEIGHT))) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      rcv_d      = '0;
      out_pos_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kuw_pkg::ST_IDLE;
      radius_q   <= 3'd5;
      width_q    <= 11'd300;
      height_q   <= 12'd225;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      rcv_q      <= '0;
      out_pos_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      dy_q       <= '0;
      dx_q       <= '0;
      wslot_q    <= '0;
      cnt_q      <= '0;
      pix_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      rcv_q      <= rcv_d;
      out_pos_q  <= out_pos_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      dy_q       <= dy_d;
      dx_q       <= dx_d;
      wslot_q    <= wslot_d;
      cnt_q      <= cnt_d;
      pix_vld_q  <= pix_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kuw_pkg::CFG_RADIUS: radius_q <= cfg_data_i[2:0];
          kuw_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
          kuw_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    tag_q     <= tag_d;
    out_pix_q <= out_pix_d;
    out_end_q <= out_end_d;
  end

  // Line store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    end
    rd_q <= mem[rd_addr];
  end

  // Chain of quadrant cells, TL first.
  assign have_c[0]  = 1'b0;
  assign score_c[0] = '0;
  assign sum_c[0]   = '0;

  for (genvar k = 0; k < NQ; k++) begin : g_cell
    kuw_cell #(.MAX_RADIUS(MAX_RADIUS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .tag_i   (tag_q[k]),
      .pix_i   (rd_q),
      .n_i     (n_cnt),
      .have_i  (have_c[k]),
      .score_i (score_c[k]),
      .sum_i   (sum_c[k]),
      .have_o  (have_c[k+1]),
      .score_o (score_c[k+1]),
      .sum_o   (sum_c[k+1])
    );
  end

  kuw_div #(.MAX_RADIUS(MAX_RADIUS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (n_cnt),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Output beat.
  assign res_o.valid     = out_vld_q;
  assign res_o.blue_out  = out_pix_q[7:0];
  assign res_o.green_out = out_pix_q[15:8];
  assign res_o.red_out   = out_pix_q[23:16];
  assign res_o.frame_end = out_end_q;

endmodule

// ===== verif/tb_kuwahara_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kuwahara filter testbench
// Streams whole frames through the filter under several geometries, predicts
// every output pixel from a software copy of the frame, and checks each
// output beat field by field while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_kuwahara_filter;

  localparam int          HalfPeriod = 6;
  localparam int          CycleLimit = 3000000;
  localparam int          DrainWait  = 400;
  localparam logic [1:0]  CFG_SPARE  = 2'd3;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       filler;
  } pix_beat_t;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } pix_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [11:0] cfg_data;

  kuw_pix_in_if  pix_if ();
  kuw_pix_out_if res_if ();

  kuwahara_filter u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_if.sink),
    .res_o     (res_if.source),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  pix_beat_t   pending_beats[$];
  pix_result_t expected_pixels[$];
  int          error_count;
  int          results_seen;
  int          cycle_count;
  int          hold_cycles;
  bit          hold_done;

  // Shadow of the filter: registers, frame counters and current frame pixels.
  logic [2:0]  sh_radius;
  logic [10:0] sh_width;
  logic [11:0] sh_height;
  int          sh_col;
  int          sh_row;
  int          sh_out;
  logic [23:0] sh_frame[int];

  // Clock.
  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
             want);
    error_count++;
  endtask

  // Appends one beat to the pending queue of the sender.
  task automatic queue_beat(input pix_beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  function automatic logic [7:0] round_mean(input int unsigned sum, input int unsigned n);
    int unsigned q;
    int unsigned rem;
    q   = sum / n;
    rem = sum % n;
    if (2 * rem > n || (2 * rem == n && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // Picks the smoothest quadrant around (y, x) and returns its rounded mean; a border pixel is returned as it is.
  function automatic logic [23:0] quadrant_mean(input int y, input int x, input int r,
                                                input int w, input int h);
    int unsigned       n;
    longint unsigned   best_score;
    longint unsigned   score;
    int unsigned       best_sum[3];
    int unsigned       s[3];
    longint unsigned   sq[3];
    logic [23:0]       p;
    int                y0;
    int                x0;
    int unsigned       v;
    n = (r + 1) * (r + 1);
    best_score = 0;
    if (y < r || x < r || y + r >= h || x + r >= w) return sh_frame[y * w + x];
    for (int q = 0; q < kuw_pkg::Quads; q++) begin
      y0 = q[1] ? y : y - r;
      x0 = q[0] ? x : x - r;
      for (int c = 0; c < 3; c++) begin
        s[c]  = 0;
        sq[c] = 0;
      end
      for (int dy = 0; dy <= r; dy++) begin
        for (int dx = 0; dx <= r; dx++) begin
          p = sh_frame[(y0 + dy) * w + x0 + dx];
          for (int c = 0; c < 3; c++) begin
            v = 32'(p[8*c +: 8]);
            s[c] += v;
            sq[c] += longint'(v) * v;
          end
        end
      end
      score = 0;
      for (int c = 0; c < 3; c++) score += longint'(n) * sq[c] - longint'(s[c]) * s[c];
      if (q == 0 || score < best_score) begin
        best_score = score;
        best_sum   = s;
      end
    end
    return {round_mean(best_sum[2], n), round_mean(best_sum[1], n),
            round_mean(best_sum[0], n)};
  endfunction

  // Advances the shadow by one accepted beat and queues any output it causes.
  task automatic predict_beat(input pix_beat_t b);
    int          r;
    int          w;
    int          h;
    int          total;
    int          received;
    logic [23:0] px;
    pix_result_t res;
    r = (int'(sh_radius) > 7) ? 7 : int'(sh_radius);
    w = (int'(sh_width) < 1) ? 1 : ((int'(sh_width) > 1024) ? 1024 : int'(sh_width));
    h = (int'(sh_height) < 1) ? 1 : int'(sh_height);
    total = w * h;
    if (!b.filler && sh_row < h) begin
      sh_frame[sh_row * w + sh_col] = {b.red, b.green, b.blue};
      sh_col++;
      if (sh_col >= w) begin
        sh_col = 0;
        sh_row++;
      end
    end
    received = (sh_row >= h) ? total : sh_row * w + sh_col;
    if (sh_out >= total) return;
    if (!(received == total || received > sh_out + r * w + r)) return;
    px = quadrant_mean(sh_out / w, sh_out % w, r, w, h);
    res.blue      = px[7:0];
    res.green     = px[15:8];
    res.red       = px[23:16];
    res.frame_end = (sh_out + 1 == total);
    expected_pixels = {expected_pixels, res};
    sh_out++;
    if (sh_out >= total) begin
      sh_col = 0;
      sh_row = 0;
      sh_out = 0;
    end
  endtask

  // Sender: bursts of beats with random gaps, fed from the pending queue.
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    bit offer;
    if (!rst_ni) begin
      pix_if.valid    <= 1'b0;
      pix_if.blue_in  <= '0;
      pix_if.green_in <= '0;
      pix_if.red_in   <= '0;
      pix_if.filler   <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
    end else begin
      offer = 1'b0;
      if (pix_if.valid && pix_if.ready) begin
        predict_beat(pending_beats[0]);
        void'(pending_beats.pop_front());
      end else if (pix_if.valid) begin
        offer = 1'b1;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
      pix_if.valid <= offer;
      if (offer) begin
        pix_if.blue_in  <= pending_beats[0].blue;
        pix_if.green_in <= pending_beats[0].green;
        pix_if.red_in   <= pending_beats[0].red;
        pix_if.filler   <= pending_beats[0].filler;
      end
    end
  end

  // Long receiver hold-off, started once while a frame is still streaming in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && results_seen >= 80) begin
      hold_cycles <= 3000;
      hold_done   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Receiver: checks each output beat and stalls on its own pattern.
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    pix_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      results_seen <= 0;
      stall_mode = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected beat, blue", int'(res_if.blue_out), -1);
        end else begin
          want = expected_pixels.pop_front();
          if (res_if.blue_out !== want.blue)
            report_mismatch("blue", int'(res_if.blue_out), int'(want.blue));
          if (res_if.green_out !== want.green)
            report_mismatch("green", int'(res_if.green_out), int'(want.green));
          if (res_if.red_out !== want.red)
            report_mismatch("red", int'(res_if.red_out), int'(want.red));
          if (res_if.frame_end !== want.frame_end)
            report_mismatch("frame_end", int'(res_if.frame_end), int'(want.frame_end));
        end
      end
      if (cycle_count % 700 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_cycles > 0) res_if.ready <= 1'b0;
      else if (stall_mode == 0) res_if.ready <= 1'b1;
      else if (stall_mode == 1) res_if.ready <= ($urandom_range(0, 3) != 0);
      else res_if.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || pix_if.valid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == kuw_pkg::CFG_RADIUS) sh_radius = data[2:0];
    else if (idx == kuw_pkg::CFG_WIDTH) sh_width = data[10:0];
    else if (idx == kuw_pkg::CFG_HEIGHT) sh_height = data;
    if (idx != CFG_SPARE) begin
      sh_col = 0;
      sh_row = 0;
      sh_out = 0;
    end
  endtask

  task automatic set_geometry(input int r, input int w, input int h);
    write_reg(kuw_pkg::CFG_RADIUS, 12'(r));
    write_reg(kuw_pkg::CFG_WIDTH, 12'(w));
    write_reg(kuw_pkg::CFG_HEIGHT, 12'(h));
  endtask

  function automatic logic [7:0] pick_value(input int style, input logic [7:0] base);
    case (style)
      1: return base;
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      3: return 8'(base + $urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queues pixels of one frame (with stray fillers) and, when the whole frame is queued,
  // the tail fillers that push out the held results; part of the tail is ignored pixels.
  task automatic queue_frame(input int r, input int w, input int h, input int style,
                             input int pixels);
    pix_beat_t  b;
    logic [7:0] base;
    int         rr;
    int         ww;
    int         hh;
    rr   = (r > 7) ? 7 : r;
    ww   = (w < 1) ? 1 : ((w > 1024) ? 1024 : w);
    hh   = (h < 1) ? 1 : h;
    base = 8'($urandom_range(0, 252));
    for (int i = 0; i < pixels; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        b.blue   = 8'($urandom_range(0, 255));
        b.green  = 8'($urandom_range(0, 255));
        b.red    = 8'($urandom_range(0, 255));
        b.filler = 1'b1;
        queue_beat(b);
      end
      b.blue   = pick_value(style, base);
      b.green  = pick_value(style, base);
      b.red    = pick_value(style, base);
      b.filler = 1'b0;
      queue_beat(b);
    end
    if (pixels < ww * hh) return;
    for (int i = 0; i < rr * ww + rr; i++) begin
      b.blue   = 8'($urandom_range(0, 255));
      b.green  = 8'($urandom_range(0, 255));
      b.red    = 8'($urandom_range(0, 255));
      b.filler = ($urandom_range(0, 4) != 0);
      queue_beat(b);
    end
  endtask

  // Stimulus.
  initial begin
    pix_beat_t b;
    int        pixel_total;
    int        r;
    int        w;
    int        h;
    logic [7:0] corner[4];
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = kuw_pkg::CFG_RADIUS;
    cfg_data    = '0;
    error_count = 0;
    cycle_count = 0;
    sh_radius   = 3'd5;
    sh_width    = 11'd300;
    sh_height   = 12'd225;
    sh_col      = 0;
    sh_row      = 0;
    sh_out      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 4x4 frame at radius 1 with extreme values, a filler in
    // mid-frame, and a pixel sent during the tail that must be ignored.
    set_geometry(1, 4, 4);
    corner = '{8'h00, 8'hFF, 8'h01, 8'h80};
    for (int i = 0; i < 16; i++) begin
      b.blue   = corner[i % 4];
      b.green  = corner[(i + 1) % 4];
      b.red    = corner[(i / 4) % 4];
      b.filler = 1'b0;
      queue_beat(b);
      if (i == 6) begin
        b.filler = 1'b1;
        queue_beat(b);
      end
    end
    b.filler = 1'b0;
    queue_beat(b);
    b.filler = 1'b1;
    repeat (4) queue_beat(b);
    wait_idle();

    // Flat image: every quadrant ties and the first one must win.
    set_geometry(1, 6, 5);
    queue_frame(1, 6, 5, 1, 30);
    wait_idle();

    // Radius 0, zero width and height, and a spare index that changes nothing.
    set_geometry(0, 0, 0);
    queue_frame(0, 1, 1, 0, 1);
    wait_idle();
    set_geometry(0, 5, 3);
    queue_frame(0, 5, 3, 0, 7);
    wait_idle();
    write_reg(CFG_SPARE, 12'hFFF);
    queue_frame(0, 5, 3, 0, 8);
    wait_idle();

    // Abandoned frame: a register write in mid-frame restarts the counters.
    set_geometry(2, 7, 6);
    queue_frame(2, 7, 6, 0, 20);
    wait_idle();
    write_reg(kuw_pkg::CFG_HEIGHT, 12'd6);
    queue_frame(2, 7, 6, 3, 42);
    wait_idle();

    // Random geometries, mostly just large enough for inner pixels.
    pixel_total = 0;
    while (pixel_total < 200) begin
      r = $urandom_range(0, 7);
      w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 10) : 2 * r + $urandom_range(1, 4);
      h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 10) : 2 * r + $urandom_range(1, 3);
      set_geometry(r, w, h);
      queue_frame(r, w, h, $urandom_range(0, 3), w * h);
      pixel_total += w * h;
      if ($urandom_range(0, 1)) begin
        queue_frame(r, w, h, $urandom_range(0, 3), w * h);
        pixel_total += w * h;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
